@@ src/oets_pkg.sv @@
// oets_pkg: shared constants and types of the odd-even transposition sorter
// used by oets_cell, oets_ctrl and odd_even_transposition_sort
package oets_pkg;

  localparam int ELEMENT_COUNT = 16;
  localparam int VALUE_WIDTH   = 16;
  localparam int CNT_W         = $clog2(ELEMENT_COUNT);

  // operation applied to the whole row of cells together
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_PHASE
  } cell_op_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } seq_state_e;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_e op;
    logic     parity;  // 0: pairs start at even positions, 1: at odd ones
  } cell_ctrl_t;

endpackage

@@ src/oets_cell.sv @@
// oets_cell: one position of the sorting row, holds one value
// depends on oets_pkg for widths and the control struct
module oets_cell (
  input  logic                              clk_i,
  input  oets_pkg::cell_ctrl_t              ctrl_i,
  input  logic                              is_first_i,
  input  logic                              is_last_i,
  input  logic                              pos_odd_i,
  input  logic [oets_pkg::VALUE_WIDTH-1:0]  left_i,
  input  logic [oets_pkg::VALUE_WIDTH-1:0]  right_i,
  output logic [oets_pkg::VALUE_WIDTH-1:0]  value_o
);
  import oets_pkg::*;

  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic                   pair_left, pair_right;

  // role of this cell in the current phase
  assign pair_left  = (pos_odd_i == ctrl_i.parity) && !is_last_i;
  assign pair_right = (pos_odd_i != ctrl_i.parity) && !is_first_i;

  // shift toward position zero, or compare-exchange with the partner
  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      OP_SHIFT: value_d = right_i;
      OP_PHASE: begin
        if (pair_left && (value_q > right_i)) begin
          value_d = right_i;
        end else if (pair_right && (left_i > value_q)) begin
          value_d = left_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

@@ src/oets_ctrl.sv @@
// oets_ctrl: sequencer for load, sort phases and emit of one list
// depends on oets_pkg for states, counts and the cell control struct
module oets_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  last_o,
  output oets_pkg::cell_ctrl_t  cell_ctrl_o
);
  import oets_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ELEMENT_COUNT - 1);

  seq_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             in_acc, out_acc;

  // state and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // handshakes taken straight from the state register
  assign in_acc  = in_valid_i && (state_q == ST_LOAD);
  assign out_acc = (state_q == ST_EMIT) && !out_stall_i;

  // next state, counter and row control
  always_comb begin
    state_d            = state_q;
    cnt_d              = cnt_q;
    in_stall_o         = 1'b1;
    out_valid_o        = 1'b0;
    last_o             = 1'b0;
    cell_ctrl_o.op     = OP_HOLD;
    cell_ctrl_o.parity = cnt_q[0];
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          cell_ctrl_o.op = OP_SHIFT;
          if (cnt_q == CNT_LAST) begin
            cnt_d   = '0;
            state_d = ST_SORT;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_SORT: begin
        cell_ctrl_o.op = OP_PHASE;
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        last_o      = (cnt_q == CNT_LAST);
        if (out_acc) begin
          cell_ctrl_o.op = OP_SHIFT;
          if (cnt_q == CNT_LAST) begin
            cnt_d   = '0;
            state_d = ST_LOAD;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule

@@ src/odd_even_transposition_sort.sv @@
// odd_even_transposition_sort: top level, row of sorting cells and sequencer
// depends on oets_pkg, oets_cell and oets_ctrl
//
// usage
//   input channel: value_i with in_valid_i / in_stall_o. ELEMENT_COUNT words
//   make one list; they are taken one per cycle while the block is loading.
//   after the last word the row runs ELEMENT_COUNT compare-exchange phases,
//   one per cycle, each cell swapping with its partner in parallel.
//   output channel: sorted_value_o and last_o with out_valid_o / out_stall_i.
//   the list leaves in ascending order from cell zero, one word per cycle
//   when not stalled; last_o marks the final word.
//   a full list passes through load, sort and emit in turn, and the shared
//   shift path of the cell row means loading waits until the previous list
//   has left.
//   stalling the receiver holds the current word and the row; the input
//   stays stalled until the last word is taken.
//   reset clears the sequencer and load count; cell contents are not reset.
module odd_even_transposition_sort (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [oets_pkg::VALUE_WIDTH-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [oets_pkg::VALUE_WIDTH-1:0]  sorted_value_o,
  output logic                              last_o
);
  import oets_pkg::*;

  cell_ctrl_t             cell_ctrl;
  logic [VALUE_WIDTH-1:0] cell_val [ELEMENT_COUNT];

  // sequencer
  oets_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .last_o      (last_o),
    .cell_ctrl_o (cell_ctrl)
  );

  // row of cells, words enter at the far end and leave at cell zero
  for (genvar i = 0; i < ELEMENT_COUNT; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_val, right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == ELEMENT_COUNT - 1) begin : g_last
      assign right_val = value_i;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    oets_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .is_first_i (i == 0),
      .is_last_i  (i == ELEMENT_COUNT - 1),
      .pos_odd_i  ((i % 2) == 1),
      .left_i     (left_val),
      .right_i    (right_val),
      .value_o    (cell_val[i])
    );
  end

  assign sorted_value_o = cell_val[0];

  // no input word is taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && !in_stall_o && out_valid_o))
    else $error("input accepted during emit");

  // last marker only on a valid word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> out_valid_o)
    else $error("last without valid");

  // after the final word leaves, loading resumes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> (!in_stall_o && !out_valid_o))
    else $error("no return to load after last word");

  // emitted words never decrease within a list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=>
      (out_valid_o && (sorted_value_o >= $past(sorted_value_o))))
    else $error("output not ascending");

endmodule
